/* hdl/multipass_centered_box_smoother_unit_assert.svh */
// Assertion macros shared by the checker of the smoother unit.
`ifndef MULTIPASS_CENTERED_BOX_SMOOTHER_UNIT_ASSERT_SVH
`define MULTIPASS_CENTERED_BOX_SMOOTHER_UNIT_ASSERT_SVH
// Same-cycle implication, disabled during reset.
`define MCBS_ASSERT_IMPL(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("smoother assertion failed");
// Next-cycle implication, disabled during reset.
`define MCBS_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("smoother assertion failed");
`endif

/* hdl/mcbs_pkg.sv */
// Package with the types and constants of the smoother unit.
package mcbs_pkg;
	localparam int SAMPLE_W   = 16;
	localparam int RADIUS_W   = 7;
	localparam int PASS_W     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT    = 2'd1;

	// Item actions.
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_FETCH = 1'b1;
endpackage

/* hdl/mcbs_if.sv */
// Channel interfaces for input items and result items.
interface mcbs_in_if;
	logic valid;
	logic ready;
	logic action;
	mcbs_pkg::sample_t sample;
	logic last;
	modport source(output valid, action, sample, last, input ready);
	modport sink(input valid, action, sample, last, output ready);
endinterface

interface mcbs_out_if;
	logic valid;
	logic ready;
	mcbs_pkg::sample_t smoothed;
	logic valid_res;
	logic end_of_sequence;
	logic overflow;
	modport source(output valid, smoothed, valid_res, end_of_sequence, overflow, input ready);
	modport sink(input valid, smoothed, valid_res, end_of_sequence, overflow, output ready);
endinterface

/* hdl/mcbs_ram.sv */
// Generic single-port-write, registered-read RAM.
module mcbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* hdl/multipass_centered_box_smoother_unit.sv */
// Top level of the multipass centered box smoother.
//
//  channel   | dir | handshake    | payload
//  ----------+-----+--------------+---------------------------------------------
//  items     | in  | valid/ready  | action, sample, last
//  results   | out | valid/ready  | smoothed, valid_res, end_of_sequence, overflow
//  cfg       | in  | cfg_we only  | cfg_index, cfg_data
//
// A load that fits is written to sample RAM A when it is taken. A fetch passes through a
// registered RAM read and then the result register. The next item can be taken in the
// cycle after the result register empties. The load flagged last starts smoothing: each
// pass primes the window sum over 2R+1 reads, then per sample runs the bit-serial divider
// of the mean, writes the result and slides the window sum. Reset clears the control
// state, not the sample RAMs. Input items are not taken while a result waits in the output register.
module multipass_centered_box_smoother_unit #(
	parameter int MAX_LENGTH = 1024,
	parameter int MAX_RADIUS = 64,
	parameter int MAX_PASSES = 15
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mcbs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mcbs_pkg::CFG_DATA_W-1:0]  cfg_data,
	mcbs_in_if.sink                          items,
	mcbs_out_if.source                       results
);
	localparam int LW  = $clog2(MAX_LENGTH + 1);
	localparam int AW  = $clog2(MAX_LENGTH);
	localparam int RW  = $clog2(MAX_RADIUS + 1);
	localparam int DW  = RW + 1;
	localparam int SW  = 17 + DW;
	localparam int QW  = SW - 1;
	localparam int PW  = LW + RW + 2;
	localparam int PCW = $clog2(MAX_PASSES + 1);
	localparam int DCW = $clog2(QW);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_FETCH    = 4'd1;
	localparam logic [3:0] ST_PASS     = 4'd2;
	localparam logic [3:0] ST_INIT_RD  = 4'd3;
	localparam logic [3:0] ST_INIT_ACC = 4'd4;
	localparam logic [3:0] ST_DIV_SET  = 4'd5;
	localparam logic [3:0] ST_DIV      = 4'd6;
	localparam logic [3:0] ST_WR       = 4'd7;
	localparam logic [3:0] ST_ADD_RD   = 4'd8;
	localparam logic [3:0] ST_ADD_ACC  = 4'd9;
	localparam logic [3:0] ST_SUB_ACC  = 4'd10;

	logic [3:0]                        state_q;
	logic [mcbs_pkg::RADIUS_W-1:0]     radius_q;
	logic [mcbs_pkg::PASS_W-1:0]       passes_q;
	logic [LW-1:0]                     len_q;
	logic [LW-1:0]                     ri_q;
	logic                              ovf_q;
	logic                              done_q;
	logic                              sel_q;
	logic [PCW-1:0]                    pass_q;
	logic [DW-1:0]                     kk_q;
	logic [AW-1:0]                     idx_q;
	logic signed [SW-1:0]              sum_q;
	logic [QW-1:0]                     dvd_q;
	logic [DW-1:0]                     rem_q;
	logic [DCW-1:0]                    dcnt_q;
	logic                              neg_q;
	logic                              out_valid_q;
	mcbs_pkg::sample_t                 smoothed_q;
	logic                              vres_q;
	logic                              eos_q;
	logic                              oflow_q;

	logic [RW-1:0]          r_eff;
	logic [DW-1:0]          d_div;
	logic [PCW-1:0]         p_eff;
	logic [AW-1:0]          n_last;
	logic signed [PW-1:0]   pos;
	logic [AW-1:0]          clamp_addr;
	logic [AW-1:0]          raddr;
	logic [15:0]            rd_a;
	logic [15:0]            rd_b;
	mcbs_pkg::sample_t      rdata;
	logic signed [SW-1:0]   sum_nx;
	logic signed [SW-1:0]   t_val;
	logic signed [SW-1:0]   m_val;
	logic [DW:0]            trial;
	logic                   ge;
	mcbs_pkg::sample_t      result;
	logic                   in_acc;
	logic                   clr;
	logic [LW-1:0]          len_eff;
	logic                   load_wr;
	logic                   we_a;
	logic                   we_b;
	logic [AW-1:0]          waddr_a;
	logic [15:0]            wdata_a;

	// Effective radius, divisor and pass count after saturation.
	always_comb begin
		if (int'(radius_q) > MAX_RADIUS) r_eff = RW'(MAX_RADIUS);
		else r_eff = RW'(radius_q);
		if (int'(passes_q) > MAX_PASSES) p_eff = PCW'(MAX_PASSES);
		else p_eff = PCW'(passes_q);
	end
	assign d_div  = {r_eff, 1'b1};
	assign n_last = AW'(len_q - LW'(1));

	// Window position for the current read, clamped to the stored sequence.
	always_comb begin
		unique case (state_q)
			ST_INIT_RD: pos = $signed(PW'(kk_q)) - $signed(PW'(r_eff));
			ST_ADD_RD:  pos = $signed(PW'(idx_q)) + $signed(PW'(r_eff)) + PW'(1);
			default:    pos = $signed(PW'(idx_q)) - $signed(PW'(r_eff));
		endcase
		if (pos < 0) clamp_addr = '0;
		else if (pos > $signed(PW'(n_last))) clamp_addr = n_last;
		else clamp_addr = AW'(pos);
	end
	assign raddr = (state_q == ST_IDLE) ? ri_q[AW-1:0] : clamp_addr;
	assign rdata = sel_q ? $signed(rd_b) : $signed(rd_a);

	// Shared accumulator adder for the running window sum.
	assign sum_nx = (state_q == ST_SUB_ACC) ? sum_q - SW'(rdata) : sum_q + SW'(rdata);

	// Rounded mean setup: floor((sum + R) / d) through an unsigned divide.
	assign t_val = sum_q + $signed(SW'(r_eff));
	assign m_val = t_val[SW-1] ? (-t_val + $signed(SW'(d_div)) - SW'(1)) : t_val;

	// One restoring division step.
	assign trial = {rem_q, dvd_q[QW-1]};
	assign ge    = trial >= {1'b0, d_div};
	assign result = mcbs_pkg::SAMPLE_W'(neg_q ? -dvd_q : dvd_q);

	// Handshake and RAM write selection.
	assign items.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign in_acc      = items.valid && items.ready;
	assign clr         = done_q;
	assign len_eff     = clr ? '0 : len_q;
	assign load_wr     = in_acc && (items.action == mcbs_pkg::ACT_LOAD) &&
	                     (len_eff < LW'(MAX_LENGTH));
	assign we_a        = load_wr || ((state_q == ST_WR) && sel_q);
	assign we_b        = (state_q == ST_WR) && !sel_q;
	assign waddr_a     = load_wr ? len_eff[AW-1:0] : idx_q;
	assign wdata_a     = load_wr ? items.sample : result;

	mcbs_ram #(.WIDTH(mcbs_pkg::SAMPLE_W), .DEPTH(MAX_LENGTH)) u_ram_a (
		.clk(clk), .we(we_a), .waddr(waddr_a), .wdata(wdata_a),
		.raddr(raddr), .rdata(rd_a)
	);

	mcbs_ram #(.WIDTH(mcbs_pkg::SAMPLE_W), .DEPTH(MAX_LENGTH)) u_ram_b (
		.clk(clk), .we(we_b), .waddr(idx_q), .wdata(result),
		.raddr(raddr), .rdata(rd_b)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= mcbs_pkg::RADIUS_W'(1);
			passes_q <= mcbs_pkg::PASS_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				mcbs_pkg::REG_WINDOW_RADIUS: radius_q <= cfg_data;
				mcbs_pkg::REG_PASS_COUNT:    passes_q <= mcbs_pkg::PASS_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// Sequencer for loads, fetches and the smoothing passes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			ri_q        <= '0;
			ovf_q       <= 1'b0;
			done_q      <= 1'b0;
			sel_q       <= 1'b0;
			pass_q      <= '0;
			kk_q        <= '0;
			idx_q       <= '0;
			sum_q       <= '0;
			dvd_q       <= '0;
			rem_q       <= '0;
			dcnt_q      <= '0;
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
			smoothed_q  <= '0;
			vres_q      <= 1'b0;
			eos_q       <= 1'b0;
			oflow_q     <= 1'b0;
		end else begin
			if (out_valid_q && results.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (items.action == mcbs_pkg::ACT_LOAD)) begin
						if (clr) begin
							done_q <= 1'b0;
							ri_q   <= '0;
							sel_q  <= 1'b0;
							ovf_q  <= 1'b0;
						end
						if (len_eff < LW'(MAX_LENGTH)) len_q <= len_eff + LW'(1);
						else ovf_q <= 1'b1;
						if (items.last) begin
							pass_q  <= '0;
							state_q <= ST_PASS;
						end
					end else if (in_acc) begin
						if (done_q && (ri_q < len_q)) begin
							state_q <= ST_FETCH;
						end else begin
							out_valid_q <= 1'b1;
							smoothed_q  <= '0;
							vres_q      <= 1'b0;
							eos_q       <= 1'b0;
							oflow_q     <= ovf_q;
						end
					end
				end
				ST_FETCH: begin
					out_valid_q <= 1'b1;
					smoothed_q  <= rdata;
					vres_q      <= 1'b1;
					eos_q       <= (ri_q + LW'(1)) == len_q;
					oflow_q     <= ovf_q;
					ri_q        <= ri_q + LW'(1);
					state_q     <= ST_IDLE;
				end
				ST_PASS: begin
					if (pass_q == p_eff) begin
						done_q  <= 1'b1;
						ri_q    <= '0;
						state_q <= ST_IDLE;
					end else begin
						sum_q   <= '0;
						kk_q    <= '0;
						state_q <= ST_INIT_RD;
					end
				end
				ST_INIT_RD: state_q <= ST_INIT_ACC;
				ST_INIT_ACC: begin
					sum_q <= sum_nx;
					if (kk_q == {r_eff, 1'b0}) begin
						idx_q   <= '0;
						state_q <= ST_DIV_SET;
					end else begin
						kk_q    <= kk_q + DW'(1);
						state_q <= ST_INIT_RD;
					end
				end
				ST_DIV_SET: begin
					neg_q   <= t_val[SW-1];
					dvd_q   <= m_val[QW-1:0];
					rem_q   <= '0;
					dcnt_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q  <= ge ? DW'(trial - {1'b0, d_div}) : trial[DW-1:0];
					dvd_q  <= {dvd_q[QW-2:0], ge};
					dcnt_q <= dcnt_q + DCW'(1);
					if (dcnt_q == DCW'(QW - 1)) state_q <= ST_WR;
				end
				ST_WR: begin
					if (idx_q == n_last) begin
						sel_q   <= !sel_q;
						pass_q  <= pass_q + PCW'(1);
						state_q <= ST_PASS;
					end else begin
						state_q <= ST_ADD_RD;
					end
				end
				ST_ADD_RD: state_q <= ST_ADD_ACC;
				ST_ADD_ACC: begin
					sum_q   <= sum_nx;
					state_q <= ST_SUB_ACC;
				end
				ST_SUB_ACC: begin
					sum_q   <= sum_nx;
					idx_q   <= idx_q + AW'(1);
					state_q <= ST_DIV_SET;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign results.valid           = out_valid_q;
	assign results.smoothed        = smoothed_q;
	assign results.valid_res       = vres_q;
	assign results.end_of_sequence = eos_q;
	assign results.overflow        = oflow_q;
endmodule

/* hdl/mcbs_checker.sv */
// Port-level checker of the smoother unit and its bind statement.
`include "multipass_centered_box_smoother_unit_assert.svh"
module mcbs_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [15:0]             smoothed,
	input logic                    valid_res,
	input logic                    end_of_sequence
);
	// An empty fetch result carries a zero sample and no end mark.
	`MCBS_ASSERT_IMPL(a_empty_zero, clk, arst_n, out_valid && !valid_res, smoothed == 16'd0 && !end_of_sequence)
	// The end mark only comes with a real result.
	`MCBS_ASSERT_IMPL(a_eos_valid, clk, arst_n, out_valid && end_of_sequence, valid_res)
	// No item is taken while a result waits.
	`MCBS_ASSERT_IMPL(a_no_take_while_full, clk, arst_n, out_valid, !in_ready)
	// A stalled result holds its sample.
	`MCBS_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(smoothed))
endmodule

bind multipass_centered_box_smoother_unit mcbs_checker u_mcbs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(items.valid),
	.in_ready(items.ready),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.smoothed(results.smoothed),
	.valid_res(results.valid_res),
	.end_of_sequence(results.end_of_sequence)
);
